>>> rtl/connect_packet_field_parser_core_assert.svh
// Assertion macros used by the parser top level.
// Each macro expects clk and rst_n in scope at the point of use.
`ifndef CONNECT_PACKET_FIELD_PARSER_CORE_ASSERT_SVH
`define CONNECT_PACKET_FIELD_PARSER_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define CPFP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define CPFP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/cpfp_pkg.sv
// ----------------------------------------------------------------------------
// cpfp_pkg
// Phase codes, status codes and the state/result records of the CONNECT
// packet field parser.
// ----------------------------------------------------------------------------
`default_nettype none

package cpfp_pkg;

  // Parse phases; the value is also the field code of the byte
  localparam logic [4:0] PH_TYPE      = 5'd0;
  localparam logic [4:0] PH_REMLEN    = 5'd1;
  localparam logic [4:0] PH_NAMELEN   = 5'd2;
  localparam logic [4:0] PH_NAME      = 5'd3;
  localparam logic [4:0] PH_LEVEL     = 5'd4;
  localparam logic [4:0] PH_FLAGS     = 5'd5;
  localparam logic [4:0] PH_KEEPALIVE = 5'd6;
  localparam logic [4:0] PH_CIDLEN    = 5'd7;
  localparam logic [4:0] PH_CID       = 5'd8;
  localparam logic [4:0] PH_WTLEN     = 5'd9;
  localparam logic [4:0] PH_WT        = 5'd10;
  localparam logic [4:0] PH_WMLEN     = 5'd11;
  localparam logic [4:0] PH_WM        = 5'd12;
  localparam logic [4:0] PH_USERLEN   = 5'd13;
  localparam logic [4:0] PH_USER      = 5'd14;
  localparam logic [4:0] PH_PASSLEN   = 5'd15;
  localparam logic [4:0] PH_PASS      = 5'd16;
  localparam logic [4:0] PH_IDLE      = 5'd17;

  // Connect flag bits that select optional payload fields
  localparam int unsigned FLAG_WILL_BIT = 2;
  localparam int unsigned FLAG_PASS_BIT = 6;
  localparam int unsigned FLAG_USER_BIT = 7;

  // Packet status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SHORT = 2'd1;
  localparam logic [1:0] ST_TRUNC = 2'd2;

  localparam int unsigned MIN_BYTES = 3;
  localparam int unsigned LEN_BYTES = 2;
  localparam logic [8:0]  SEEN_MAX  = 9'd511;

  // Parser state carried from byte to byte
  typedef struct packed {
    logic [4:0]  phase;
    logic [15:0] bytes_left;
    logic [7:0]  len_high;
    logic [7:0]  flags;
    logic [7:0]  remaining;
    logic [8:0]  seen;
    logic [3:0]  pkt_type;
  } state_t;

  // One tagged output byte
  typedef struct packed {
    logic [4:0]  field_code;
    logic [7:0]  byte_value;
    logic        field_last;
    logic [15:0] length_value;
    logic [3:0]  packet_type;
    logic [7:0]  connect_flags;
    logic        packet_done;
    logic [1:0]  status;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/cpfp_if.sv
// ----------------------------------------------------------------------------
// cpfp_if
// Valid/ready channels of the parser: raw packet bytes in, tagged bytes out.
// ----------------------------------------------------------------------------
`default_nettype none

interface cpfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface cpfp_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  field_code;
  logic [7:0]  byte_value;
  logic        field_last;
  logic [15:0] length_value;
  logic [3:0]  packet_type;
  logic [7:0]  connect_flags;
  logic        packet_done;
  logic [1:0]  status;

  modport source (output valid, output field_code, output byte_value,
                  output field_last, output length_value, output packet_type,
                  output connect_flags, output packet_done, output status,
                  input ready);
  modport sink   (input valid, input field_code, input byte_value,
                  input field_last, input length_value, input packet_type,
                  input connect_flags, input packet_done, input status,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/cpfp_step.sv
// ----------------------------------------------------------------------------
// cpfp_step
// Per-byte parse step: from the current state and one byte, produce the
// tagged result and the state for the next byte.
// ----------------------------------------------------------------------------
`default_nettype none

module cpfp_step (
  input  var cpfp_pkg::state_t  cur,
  input  wire logic [7:0]       data_byte,
  input  wire logic             last_byte,
  output cpfp_pkg::state_t      state_nxt,
  output cpfp_pkg::result_t     res_nxt
);

  // Phases that collect a big-endian 16-bit value
  function automatic logic is_len(input logic [4:0] p);
    return p inside {cpfp_pkg::PH_NAMELEN, cpfp_pkg::PH_KEEPALIVE,
                     cpfp_pkg::PH_CIDLEN, cpfp_pkg::PH_WTLEN,
                     cpfp_pkg::PH_WMLEN, cpfp_pkg::PH_USERLEN,
                     cpfp_pkg::PH_PASSLEN};
  endfunction

  // Phase that follows a finished or empty string field
  function automatic logic [4:0] after_string(input logic [4:0] p,
                                              input logic [7:0] f);
    logic [4:0] q;
    q = cpfp_pkg::PH_IDLE;
    case (p)
      cpfp_pkg::PH_NAME: q = cpfp_pkg::PH_LEVEL;
      cpfp_pkg::PH_WT:   q = cpfp_pkg::PH_WMLEN;
      cpfp_pkg::PH_CID: begin
        if (f[cpfp_pkg::FLAG_WILL_BIT])      q = cpfp_pkg::PH_WTLEN;
        else if (f[cpfp_pkg::FLAG_USER_BIT]) q = cpfp_pkg::PH_USERLEN;
        else if (f[cpfp_pkg::FLAG_PASS_BIT]) q = cpfp_pkg::PH_PASSLEN;
      end
      cpfp_pkg::PH_WM: begin
        if (f[cpfp_pkg::FLAG_USER_BIT])      q = cpfp_pkg::PH_USERLEN;
        else if (f[cpfp_pkg::FLAG_PASS_BIT]) q = cpfp_pkg::PH_PASSLEN;
      end
      cpfp_pkg::PH_USER: begin
        if (f[cpfp_pkg::FLAG_PASS_BIT])      q = cpfp_pkg::PH_PASSLEN;
      end
      default: q = cpfp_pkg::PH_IDLE;
    endcase
    return q;
  endfunction

  logic [4:0]  ph;
  logic        was_idle;
  logic        natural_end;
  logic        fl;
  logic [15:0] lv;
  logic [15:0] left_dec;
  logic [4:0]  tgt;
  logic [1:0]  st;

  always_comb begin
    ph          = (cur.phase > cpfp_pkg::PH_IDLE) ? cpfp_pkg::PH_IDLE : cur.phase;
    was_idle    = (ph == cpfp_pkg::PH_IDLE);
    state_nxt   = cur;
    state_nxt.phase = ph;
    fl          = 1'b0;
    lv          = '0;
    tgt         = cpfp_pkg::PH_IDLE;
    left_dec    = (cur.bytes_left == '0) ? '0 : cur.bytes_left - 16'd1;

    // Advance the phase for this byte
    case (ph)
      cpfp_pkg::PH_TYPE: begin
        state_nxt.pkt_type   = data_byte[7:4];
        state_nxt.flags      = '0;
        state_nxt.remaining  = '0;
        fl                   = 1'b1;
        state_nxt.phase      = cpfp_pkg::PH_REMLEN;
        state_nxt.bytes_left = '0;
      end
      cpfp_pkg::PH_REMLEN: begin
        state_nxt.remaining  = data_byte;
        fl                   = 1'b1;
        state_nxt.phase      = cpfp_pkg::PH_NAMELEN;
        state_nxt.bytes_left = 16'(cpfp_pkg::LEN_BYTES);
      end
      cpfp_pkg::PH_LEVEL: begin
        fl                   = 1'b1;
        state_nxt.phase      = cpfp_pkg::PH_FLAGS;
        state_nxt.bytes_left = '0;
      end
      cpfp_pkg::PH_FLAGS: begin
        state_nxt.flags      = data_byte;
        fl                   = 1'b1;
        state_nxt.phase      = cpfp_pkg::PH_KEEPALIVE;
        state_nxt.bytes_left = 16'(cpfp_pkg::LEN_BYTES);
      end
      cpfp_pkg::PH_IDLE: begin
      end
      default: begin
        if (is_len(ph)) begin
          if (cur.bytes_left >= 16'(cpfp_pkg::LEN_BYTES)) begin
            // High byte of the value: hold it
            state_nxt.len_high   = data_byte;
            state_nxt.bytes_left = 16'd1;
          end else begin
            lv = {cur.len_high, data_byte};
            fl = 1'b1;
            if (ph == cpfp_pkg::PH_KEEPALIVE) begin
              // Header alone fills the remaining length: skip the payload
              if ({1'b0, cur.seen} + 10'd1 ==
                  {2'b00, cur.remaining} + 10'(cpfp_pkg::LEN_BYTES)) begin
                state_nxt.phase      = cpfp_pkg::PH_IDLE;
                state_nxt.bytes_left = '0;
              end else begin
                state_nxt.phase      = cpfp_pkg::PH_CIDLEN;
                state_nxt.bytes_left = 16'(cpfp_pkg::LEN_BYTES);
              end
            end else if (lv != '0) begin
              state_nxt.phase      = ph + 5'd1;
              state_nxt.bytes_left = lv;
            end else begin
              // Empty string: go straight to the field after it
              tgt                  = after_string(ph + 5'd1, cur.flags);
              state_nxt.phase      = tgt;
              state_nxt.bytes_left = is_len(tgt) ? 16'(cpfp_pkg::LEN_BYTES) : '0;
            end
          end
        end else begin
          // String byte: count down
          state_nxt.bytes_left = left_dec;
          if (left_dec == '0) begin
            fl                   = 1'b1;
            tgt                  = after_string(ph, cur.flags);
            state_nxt.phase      = tgt;
            state_nxt.bytes_left = is_len(tgt) ? 16'(cpfp_pkg::LEN_BYTES) : '0;
          end
        end
      end
    endcase

    // Packet end and status
    natural_end = !was_idle && (state_nxt.phase == cpfp_pkg::PH_IDLE);
    st = cpfp_pkg::ST_OK;
    if (last_byte && !was_idle && !natural_end) begin
      st = (cur.seen < 9'(cpfp_pkg::MIN_BYTES - 1)) ? cpfp_pkg::ST_SHORT
                                                     : cpfp_pkg::ST_TRUNC;
    end

    res_nxt.field_code    = ph;
    res_nxt.byte_value    = data_byte;
    res_nxt.field_last    = fl;
    res_nxt.length_value  = lv;
    res_nxt.packet_type   = state_nxt.pkt_type;
    res_nxt.connect_flags = state_nxt.flags;
    res_nxt.packet_done   = was_idle || natural_end || last_byte;
    res_nxt.status        = st;

    // Rearm for the next packet, or count the byte
    if (last_byte) begin
      state_nxt.phase      = cpfp_pkg::PH_TYPE;
      state_nxt.bytes_left = '0;
      state_nxt.len_high   = '0;
      state_nxt.seen       = '0;
    end else if (cur.seen != cpfp_pkg::SEEN_MAX) begin
      state_nxt.seen       = cur.seen + 9'd1;
    end
  end

endmodule

`default_nettype wire

>>> rtl/connect_packet_field_parser_core.sv
// One CONNECT packet byte is accepted per cycle while the sink keeps taking
// results, and it comes out tagged with its field through the input register,
// then the result register, one result per byte. Throughput is one byte per
// clock for any packet length unless the sink holds back: the whole per-byte
// phase update is combinational between the input register and the result
// register, so back-to-back bytes do not wait on one another. in_if.ready
// drops only when both registers hold bytes and the result is not being taken.
// ----------------------------------------------------------------------------
// connect_packet_field_parser_core
// Top level: input register, parse step, result register and parser state.
// ----------------------------------------------------------------------------
`default_nettype none

`include "connect_packet_field_parser_core_assert.svh"

module connect_packet_field_parser_core (
  input  wire logic   clk,
  input  wire logic   rst_n,
  cpfp_in_if.sink     in_if,
  cpfp_out_if.source  out_if
);

  logic              s1_valid_r;
  logic [7:0]        s1_byte_r;
  logic              s1_last_r;
  logic              out_valid_r;
  cpfp_pkg::state_t  state_r;
  cpfp_pkg::state_t  state_nxt;
  cpfp_pkg::result_t res_r;
  cpfp_pkg::result_t res_nxt;
  logic              out_load;
  logic              step_fire;
  logic              in_fire;

  // Handshake steering
  assign out_load    = !out_valid_r || out_if.ready;
  assign step_fire   = s1_valid_r && out_load;
  assign in_if.ready = !s1_valid_r || out_load;
  assign in_fire     = in_if.valid && in_if.ready;

  // Hold the accepted transaction in the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (step_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_if.data_byte;
      s1_last_r <= in_if.last_byte;
    end
  end

  // Parse one byte
  cpfp_step u_step (
    .cur       (state_r),
    .data_byte (s1_byte_r),
    .last_byte (s1_last_r),
    .state_nxt (state_nxt),
    .res_nxt   (res_nxt)
  );

  // Advance parser state on each parsed byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase      <= cpfp_pkg::PH_TYPE;
      state_r.bytes_left <= '0;
      state_r.len_high   <= '0;
      state_r.flags      <= '0;
      state_r.remaining  <= '0;
      state_r.seen       <= '0;
      state_r.pkt_type   <= '0;
    end else if (step_fire) begin
      state_r <= state_nxt;
    end
  end

  // Hold the result until the sink takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.field_code    = res_r.field_code;
  assign out_if.byte_value    = res_r.byte_value;
  assign out_if.field_last    = res_r.field_last;
  assign out_if.length_value  = res_r.length_value;
  assign out_if.packet_type   = res_r.packet_type;
  assign out_if.connect_flags = res_r.connect_flags;
  assign out_if.packet_done   = res_r.packet_done;
  assign out_if.status        = res_r.status;

  // Checks
  `CPFP_ASSERT_NOW(a_phase_range, 1'b1, state_r.phase <= cpfp_pkg::PH_IDLE,
                   "phase out of range")
  `CPFP_ASSERT_NEXT(a_last_rearms, step_fire && s1_last_r,
                    state_r.phase == cpfp_pkg::PH_TYPE && state_r.seen == 9'd0,
                    "last byte did not rearm parser")
  `CPFP_ASSERT_NOW(a_status_done, out_valid_r && res_r.status != cpfp_pkg::ST_OK,
                   res_r.packet_done, "error status without packet end")
  `CPFP_ASSERT_NOW(a_ignored_not_last,
                   out_valid_r && res_r.field_code == cpfp_pkg::PH_IDLE,
                   !res_r.field_last && res_r.packet_done,
                   "ignored byte tagged as field end")

endmodule

`default_nettype wire
